// ===== rtl/tdcmap_pkg.sv =====
// Package for the TDC hit decoder: word codes, field widths, wiring table.
// Used by tdc_hit_decode_channel_map, tdcmap_checker and the testbench; no dependencies.
package tdcmap_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NUM_PADS    = 192;
    localparam int ADDR_W      = $clog2(NUM_PADS);
    localparam int HIT_COUNT_W = 32;
    localparam int NUM_MODULES = 4;
    localparam int NUM_WPADS   = 6;

    localparam logic [3:0] NIB_SEPARATOR = 4'hE;
    localparam logic [3:0] NIB_HEADER    = 4'h2;
    localparam logic [3:0] NIB_TRAY      = 4'hC;
    localparam logic [3:0] NIB_LEADING   = 4'h4;
    localparam logic [3:0] NIB_TRAILING  = 4'h5;

    typedef enum logic [2:0] {
        KIND_SEPARATOR = 3'd0,
        KIND_HEADER    = 3'd1,
        KIND_TRAY      = 3'd2,
        KIND_HIT       = 3'd3,
        KIND_BAD_EDGE  = 3'd4,
        KIND_UNMAPPED  = 3'd5
    } word_kind_t;

    // wiring: per module (row) and pad (column), the chip and its channel
    localparam logic [1:0] WIRE_CHIP [NUM_MODULES][NUM_WPADS] = '{
        '{2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1},
        '{2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0},
        '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2},
        '{2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1}
    };
    localparam logic [2:0] WIRE_CHAN [NUM_MODULES][NUM_WPADS] = '{
        '{3'd7, 3'd7, 3'd0, 3'd2, 3'd5, 3'd6},
        '{3'd7, 3'd4, 3'd4, 3'd2, 3'd3, 3'd6},
        '{3'd0, 3'd2, 3'd3, 3'd3, 3'd1, 3'd6},
        '{3'd0, 3'd5, 3'd1, 3'd4, 3'd5, 3'd1}
    };

    typedef struct packed {
        logic       found;
        logic [1:0] module_sel;
        logic [2:0] pad;
    } wire_hit_t;

    // first match in row-major order
    function automatic wire_hit_t wire_lookup(input logic [1:0] chip, input logic [2:0] chan);
        wire_hit_t res;
        res = '0;
        for (int m = 0; m < NUM_MODULES; m++) begin
            for (int p = 0; p < NUM_WPADS; p++) begin
                if (!res.found && WIRE_CHIP[m][p] == chip && WIRE_CHAN[m][p] == chan) begin
                    res.found      = 1'b1;
                    res.module_sel = 2'(m);
                    res.pad        = 3'(p);
                end
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/tdc_hit_decode_channel_map.sv =====
// Top level of the TDC hit decoder with per-pad, per-edge hit counters.
// Depends on tdcmap_pkg.

// Takes one 32-bit readout word per transaction and returns one result per word.
// Accepts one word per cycle while the output is not stalled; each word is
// registered in stage 1 and then in the output register. Counters live in two
// 192-entry synchronous RAMs (leading, trailing edge) updated by read-modify-write,
// with a one-entry write bypass for back-to-back hits on the same pad. After reset
// the block clears all 192 entries of both RAMs with s_axis_tready low.
module tdc_hit_decode_channel_map
    import tdcmap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] board_index, [4:3] chip_index, [7:5] chip_channel, [28:8] hit_time,
    // [33:29] module_index, [36:34] pad_index, [68:37] hit_count, [69] half_tray
    output logic [71:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser    // [2:0] word_kind, [3] trailing_edge
);

    // ---------------- control registers ----------------
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              half_tray_reg, half_tray_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic              fwd_valid_reg, fwd_valid_next;

    // ---------------- stage 1 payload ----------------
    word_kind_t        s1_kind_reg;
    logic              s1_trail_reg;
    logic [2:0]        s1_board_reg;
    logic [1:0]        s1_chip_reg;
    logic [2:0]        s1_chan_reg;
    logic [20:0]       s1_time_reg;
    logic [4:0]        s1_module_reg;
    logic [2:0]        s1_pad_reg;
    logic              s1_half_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    logic [ADDR_W-1:0]      fwd_addr_reg;
    logic                   fwd_trail_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic [COUNT_WIDTH-1:0] lead_mem [NUM_PADS];
    logic [COUNT_WIDTH-1:0] trail_mem [NUM_PADS];
    logic [COUNT_WIDTH-1:0] lead_rd_reg, trail_rd_reg;

    logic [71:0] m_data_reg;
    logic [3:0]  m_user_reg;

    // ---------------- decode ----------------
    logic              s_accept, s1_adv;
    logic [3:0]        nib;
    word_kind_t        d_kind;
    logic              d_trail;
    logic [2:0]        d_board;
    logic [1:0]        d_chip;
    logic [2:0]        d_chan;
    logic [20:0]       d_time;
    logic [4:0]        d_module;
    logic [2:0]        d_pad;
    logic [ADDR_W-1:0] d_addr;
    wire_hit_t         wl;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign nib      = s_axis_tdata[31:28];
    assign wl       = wire_lookup(s_axis_tdata[25:24], s_axis_tdata[23:21]);

    always_comb
    begin
        d_kind   = KIND_BAD_EDGE;
        d_trail  = 1'b0;
        d_board  = '0;
        d_chip   = '0;
        d_chan   = '0;
        d_time   = '0;
        d_module = '0;
        d_pad    = '0;
        case (nib)
            NIB_SEPARATOR: d_kind = KIND_SEPARATOR;
            NIB_HEADER:    d_kind = KIND_HEADER;
            NIB_TRAY:      d_kind = KIND_TRAY;
            default:
            begin
                if (nib inside {NIB_LEADING, NIB_TRAILING})
                begin
                    d_trail = (nib == NIB_TRAILING);
                    d_board = {half_tray_reg, s_axis_tdata[27:26]};
                    d_chip  = s_axis_tdata[25:24];
                    d_chan  = s_axis_tdata[23:21];
                    d_time  = {s_axis_tdata[18:0], s_axis_tdata[20:19]};
                    if (wl.found)
                    begin
                        d_kind   = KIND_HIT;
                        d_module = {d_board, wl.module_sel};
                        d_pad    = wl.pad;
                    end
                    else
                    begin
                        d_kind = KIND_UNMAPPED;
                    end
                end
            end
        endcase
        // board*24 + module*6 + pad
        d_addr = ADDR_W'({d_board, 4'b0}) + ADDR_W'({d_board, 3'b0})
               + ADDR_W'({wl.module_sel, 2'b0}) + ADDR_W'({wl.module_sel, 1'b0})
               + ADDR_W'(d_pad);
    end

    // ---------------- counter update ----------------
    logic [COUNT_WIDTH-1:0] cnt_cur, cnt_new;
    logic                   fwd_hit, s1_write;
    logic [63:0]            cnt_ext;

    assign fwd_hit  = fwd_valid_reg && fwd_addr_reg == s1_addr_reg
                   && fwd_trail_reg == s1_trail_reg;
    assign cnt_cur  = fwd_hit ? fwd_data_reg : (s1_trail_reg ? trail_rd_reg : lead_rd_reg);
    assign cnt_new  = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
    assign s1_write = s1_adv && s1_kind_reg == KIND_HIT;
    assign cnt_ext  = 64'(cnt_new);

    logic                   lead_we, trail_we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    always_comb
    begin
        if (clearing_reg)
        begin
            lead_we  = 1'b1;
            trail_we = 1'b1;
            wr_addr  = clr_addr_reg;
            wr_data  = '0;
        end
        else
        begin
            lead_we  = s1_write && !s1_trail_reg;
            trail_we = s1_write && s1_trail_reg;
            wr_addr  = s1_addr_reg;
            wr_data  = cnt_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lead_we)
        begin
            lead_mem[wr_addr] <= wr_data;
        end
        if (trail_we)
        begin
            trail_mem[wr_addr] <= wr_data;
        end
        if (s_accept)
        begin
            lead_rd_reg  <= lead_mem[d_addr];
            trail_rd_reg <= trail_mem[d_addr];
        end
    end

    // ---------------- control ----------------
    always_comb
    begin
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        half_tray_next = half_tray_reg;
        s1_valid_next  = s1_valid_reg;
        m_valid_next   = m_valid_reg;
        fwd_valid_next = fwd_valid_reg || s1_write;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(NUM_PADS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        if (s_accept && nib == NIB_TRAY)
        begin
            half_tray_next = s_axis_tdata[0];
        end
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            half_tray_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            half_tray_reg <= half_tray_next;
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_kind_reg   <= d_kind;
            s1_trail_reg  <= d_trail;
            s1_board_reg  <= d_board;
            s1_chip_reg   <= d_chip;
            s1_chan_reg   <= d_chan;
            s1_time_reg   <= d_time;
            s1_module_reg <= d_module;
            s1_pad_reg    <= d_pad;
            s1_half_reg   <= half_tray_next;
            s1_addr_reg   <= d_addr;
        end
        if (s1_write)
        begin
            fwd_addr_reg  <= s1_addr_reg;
            fwd_trail_reg <= s1_trail_reg;
            fwd_data_reg  <= cnt_new;
        end
        if (s1_adv)
        begin
            m_user_reg <= {s1_trail_reg, s1_kind_reg};
            m_data_reg <= {2'b00, s1_half_reg,
                           (s1_kind_reg == KIND_HIT) ? cnt_ext[HIT_COUNT_W-1:0]
                                                     : HIT_COUNT_W'(0),
                           s1_pad_reg, s1_module_reg, s1_time_reg,
                           s1_chan_reg, s1_chip_reg, s1_board_reg};
        end
    end

    assign s_axis_tready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ===== rtl/tdcmap_checker.sv =====
// Port-level assertions for tdc_hit_decode_channel_map, bound to the top level.
// Depends on tdcmap_pkg.
module tdcmap_checker
    import tdcmap_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    logic kind_hit, kind_unmapped, kind_plain;

    assign kind_hit      = m_axis_tuser[2:0] == KIND_HIT;
    assign kind_unmapped = m_axis_tuser[2:0] == KIND_UNMAPPED;
    assign kind_plain    = m_axis_tuser[2:0] == KIND_SEPARATOR
                        || m_axis_tuser[2:0] == KIND_HEADER
                        || m_axis_tuser[2:0] == KIND_TRAY
                        || m_axis_tuser[2:0] == KIND_BAD_EDGE;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result transaction changed while stalled");

    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && kind_hit |-> m_axis_tdata[33:31] == m_axis_tdata[2:0]
                                   && m_axis_tdata[36:34] < 3'd6
                                   && m_axis_tdata[68:37] != 32'd0
                                   && m_axis_tdata[4:3] != 2'd3)
        else $error("hit transaction with inconsistent module, pad or count");

    a_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && kind_unmapped |-> m_axis_tdata[4:3] == 2'd3
                                        && m_axis_tdata[68:29] == 40'd0)
        else $error("unmapped transaction not on chip 3 or carries a count");

    a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && kind_plain |-> m_axis_tdata[68:0] == 69'd0
                                     && !m_axis_tuser[3] && m_axis_tdata[71:70] == 2'd0)
        else $error("non-hit transaction carries hit fields");

endmodule

bind tdc_hit_decode_channel_map tdcmap_checker u_tdcmap_checker (.*);

// ===== bench/tb_tdc_hit_decode_channel_map.sv =====
// Testbench for tdc_hit_decode_channel_map: feeds readout words, predicts each result
// with an in-bench decoder and pad counters, and checks every output transaction.
// Depends on tdcmap_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_tdc_hit_decode_channel_map;
    import tdcmap_pkg::*;

    localparam int CALM_TAIL = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_WORDS = 700;

    // wired chip and channel per module (row) and pad (column)
    localparam logic [1:0] PAD_CHIP [4][6] = '{
        '{2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1},
        '{2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0},
        '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2},
        '{2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1}
    };
    localparam logic [2:0] PAD_CHAN [4][6] = '{
        '{3'd7, 3'd7, 3'd0, 3'd2, 3'd5, 3'd6},
        '{3'd7, 3'd4, 3'd4, 3'd2, 3'd3, 3'd6},
        '{3'd0, 3'd2, 3'd3, 3'd3, 3'd1, 3'd6},
        '{3'd0, 3'd5, 3'd1, 3'd4, 3'd5, 3'd1}
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic        trailing;
        logic [2:0]  board;
        logic [1:0]  chip;
        logic [2:0]  chan;
        logic [20:0] hit_time;
        logic [4:0]  mod_idx;
        logic [2:0]  pad;
        logic [31:0] count;
        logic        half;
    } hit_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    logic [31:0] word_q[$];
    hit_result_t result_q[$];

    logic                   tray_half;
    logic [COUNT_WIDTH-1:0] lead_hits [NUM_PADS];
    logic [COUNT_WIDTH-1:0] trail_hits [NUM_PADS];

    int errors = 0;
    int words_sent = 0;
    int idle_pct = 10;
    int src_gap = 0;
    int sink_gap = 0;
    int stall_cycles = 0;

    tdc_hit_decode_channel_map dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic decode_word(input logic [31:0] w);
        hit_result_t r;
        logic [3:0]  tdc;
        logic        found;
        logic [1:0]  msel;
        logic [2:0]  psel;
        int          slot;
        r = '0;
        found = 1'b0;
        msel = '0;
        psel = '0;
        case (w[31:28])
            NIB_SEPARATOR: r.kind = KIND_SEPARATOR;
            NIB_HEADER:    r.kind = KIND_HEADER;
            NIB_TRAY:
            begin
                tray_half = w[0];
                r.kind = KIND_TRAY;
            end
            NIB_LEADING, NIB_TRAILING:
            begin
                tdc = w[27:24];
                r.trailing = (w[31:28] == NIB_TRAILING);
                r.board = {tray_half, tdc[3:2]};
                r.chip = tdc[1:0];
                r.chan = w[23:21];
                r.hit_time = {w[18:0], w[20:19]};
                for (int m = 0; m < 4; m++)
                begin
                    for (int p = 0; p < 6; p++)
                    begin
                        if (!found && PAD_CHIP[m][p] == r.chip && PAD_CHAN[m][p] == r.chan)
                        begin
                            found = 1'b1;
                            msel = 2'(m);
                            psel = 3'(p);
                        end
                    end
                end
                if (!found)
                    r.kind = KIND_UNMAPPED;
                else
                begin
                    r.kind = KIND_HIT;
                    slot = r.board * 24 + msel * 6 + psel;
                    if (r.trailing)
                    begin
                        if (trail_hits[slot] != '1)
                            trail_hits[slot] = trail_hits[slot] + 1'b1;
                        r.count = trail_hits[slot][31:0];
                    end
                    else
                    begin
                        if (lead_hits[slot] != '1)
                            lead_hits[slot] = lead_hits[slot] + 1'b1;
                        r.count = lead_hits[slot][31:0];
                    end
                    r.mod_idx = {r.board, msel};
                    r.pad = psel;
                end
            end
            default: r.kind = KIND_BAD_EDGE;
        endcase
        r.half = tray_half;
        result_q.push_back(r);
    endtask

    task automatic report(input string fld, input logic [31:0] exp_v, input logic [31:0] act_v);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fld, exp_v, act_v);
        errors++;
    endtask

    task automatic check_result();
        hit_result_t e;
        if (result_q.size() == 0)
        begin
            $display("%0t ns: unexpected transaction, tuser %0h tdata %0h", $time,
                     m_axis_tuser, m_axis_tdata);
            errors++;
        end
        else
        begin
            e = result_q.pop_front();
            if (m_axis_tuser[2:0] !== e.kind)
                report("word_kind", e.kind, m_axis_tuser[2:0]);
            if (m_axis_tuser[3] !== e.trailing)
                report("trailing_edge", e.trailing, m_axis_tuser[3]);
            if (m_axis_tdata[2:0] !== e.board)
                report("board_index", e.board, m_axis_tdata[2:0]);
            if (m_axis_tdata[4:3] !== e.chip)
                report("chip_index", e.chip, m_axis_tdata[4:3]);
            if (m_axis_tdata[7:5] !== e.chan)
                report("chip_channel", e.chan, m_axis_tdata[7:5]);
            if (m_axis_tdata[28:8] !== e.hit_time)
                report("hit_time", e.hit_time, m_axis_tdata[28:8]);
            if (m_axis_tdata[33:29] !== e.mod_idx)
                report("module_index", e.mod_idx, m_axis_tdata[33:29]);
            if (m_axis_tdata[36:34] !== e.pad)
                report("pad_index", e.pad, m_axis_tdata[36:34]);
            if (m_axis_tdata[68:37] !== e.count)
                report("hit_count", e.count, m_axis_tdata[68:37]);
            if (m_axis_tdata[69] !== e.half)
                report("half_tray", e.half, m_axis_tdata[69]);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_word(s_axis_tdata);
                words_sent <= words_sent + 1;
                if (words_sent % 64 == 63)
                begin
                    case ($urandom_range(0, 2))
                        0: idle_pct <= 0;
                        1: idle_pct <= 6;
                        default: idle_pct <= 25;
                    endcase
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (word_q.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (word_q.size() > CALM_TAIL && $urandom_range(0, 99) < idle_pct)
                begin
                    src_gap <= $urandom_range(0, 15);
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= word_q.pop_front();
                end
            end
        end
    end

    // monitor and sink
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (word_q.size() > CALM_TAIL && $urandom_range(0, 99) < idle_pct)
            begin
                sink_gap <= $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_tdc_hit_decode_channel_map: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [31:0] rnd;
        logic [3:0]  nib;
        logic [3:0]  last_tdc;
        logic [2:0]  last_chan;
        int          nhits;
        int          target;

        rst_n = 1'b0;
        tray_half = 1'b0;
        for (int i = 0; i < NUM_PADS; i++)
        begin
            lead_hits[i] = '0;
            trail_hits[i] = '0;
        end

        // directed words
        word_q.push_back({NIB_SEPARATOR, 28'h0000000});
        word_q.push_back({NIB_SEPARATOR, 28'hFFFFFFF});
        word_q.push_back({NIB_HEADER, 28'hFFFFFFF});
        word_q.push_back({NIB_LEADING, 4'h0, 3'd7, 21'h000000});
        word_q.push_back({NIB_TRAILING, 4'hE, 3'd7, 21'h1FFFFF});
        word_q.push_back({NIB_LEADING, 4'h3, 3'd0, 21'h0AAAAA});
        word_q.push_back({NIB_TRAILING, 4'hF, 3'd7, 21'h1FFFFF});
        word_q.push_back({NIB_TRAY, 28'h0000001});
        word_q.push_back({NIB_LEADING, 4'hD, 3'd3, 21'h155555});
        word_q.push_back({NIB_TRAILING, 4'h9, 3'd2, 21'h000001});
        word_q.push_back({NIB_TRAILING, 4'h9, 3'd2, 21'h100000});
        word_q.push_back({NIB_TRAILING, 4'h9, 3'd2, 21'h080000});
        word_q.push_back({NIB_TRAY, 28'hFFFFFFE});
        word_q.push_back({NIB_LEADING, 4'hD, 3'd3, 21'h1FFFFF});
        for (int n = 0; n < 16; n++)
        begin
            nib = 4'(n);
            if (nib != NIB_SEPARATOR && nib != NIB_HEADER && nib != NIB_TRAY &&
                nib != NIB_LEADING && nib != NIB_TRAILING)
                word_q.push_back({nib, 28'h5A5A5A5});
        end

        // random frames: optional tray header, header, hits, optional separator, with noise between
        target = word_q.size() + RANDOM_WORDS;
        last_tdc = 4'h0;
        last_chan = 3'd0;
        while (word_q.size() < target)
        begin
            rnd = $urandom();
            case ($urandom_range(0, 9))
                0: word_q.push_back(rnd);
                1:
                begin
                    do
                        nib = 4'($urandom_range(0, 15));
                    while (nib == NIB_SEPARATOR || nib == NIB_HEADER || nib == NIB_TRAY ||
                           nib == NIB_LEADING || nib == NIB_TRAILING);
                    word_q.push_back({nib, rnd[27:0]});
                end
                default:
                begin
                    if ($urandom_range(0, 3) != 0)
                        word_q.push_back({NIB_TRAY, rnd[27:0]});
                    rnd = $urandom();
                    word_q.push_back({NIB_HEADER, rnd[27:0]});
                    nhits = $urandom_range(1, 12);
                    for (int h = 0; h < nhits; h++)
                    begin
                        rnd = $urandom();
                        nib = $urandom_range(0, 1) ? NIB_TRAILING : NIB_LEADING;
                        if ($urandom_range(0, 2) == 0)
                            word_q.push_back({nib, last_tdc, last_chan, rnd[20:0]});
                        else
                        begin
                            last_tdc = rnd[27:24];
                            last_chan = rnd[23:21];
                            word_q.push_back({nib, rnd[27:0]});
                        end
                    end
                    rnd = $urandom();
                    if ($urandom_range(0, 4) != 0)
                        word_q.push_back({NIB_SEPARATOR, rnd[27:0]});
                end
            endcase
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (word_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0 && result_q.size() == 0)
            $display("tb_tdc_hit_decode_channel_map: done, clean");
        else
            $display("tb_tdc_hit_decode_channel_map: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tdcmap_pkg.sv
rtl/tdc_hit_decode_channel_map.sv
rtl/tdcmap_checker.sv
bench/tb_tdc_hit_decode_channel_map.sv
